// ----- hdl/ltinv_pkg.sv -----
package ltinv_pkg;

    localparam int MAX_ORDER = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int CELLS     = MAX_ORDER * MAX_ORDER;
    localparam int VALUE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int STAT_W    = 2;
    localparam int ACC_W     = 50;
    localparam int HALF_W    = 25;
    localparam int PART_W    = HALF_W + VALUE_W;
    localparam int FULL_W    = 2 * HALF_W + VALUE_W;
    localparam int QUO_W     = 2 * FRAC_W + 1;
    localparam int INV_W     = VALUE_W + STAT_W;
    localparam int CFG_W     = 16;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UPPER = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd3;

    localparam logic CFG_SIZE = 1'b0;
    localparam logic CFG_TOL  = 1'b1;

    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIAG_RD,
        ST_DIAG_CHK,
        ST_DIV,
        ST_DIAG_WR,
        ST_OFF,
        ST_DOT,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_FIN_WR,
        ST_ROW_END,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    function automatic logic [VALUE_W-1:0] mag32(input logic [VALUE_W-1:0] v);
        return v[VALUE_W-1] ? (~v + 1'b1) : v;
    endfunction

    // any zero diagonal among rows lo..hi
    function automatic logic zero_span(input logic [MAX_ORDER-1:0] zd,
                                       input logic [IDX_W-1:0] hi,
                                       input logic [IDX_W-1:0] lo);
        logic hit;
        hit = 1'b0;
        for (int t = 0; t < MAX_ORDER; t++) begin
            if (IDX_W'(t) >= lo && IDX_W'(t) <= hi && zd[t])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ----- hdl/ltinv_ram.sv -----
module ltinv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/ltinv_recip.sv -----
module ltinv_recip
    import ltinv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] divisor,
    output logic               done,
    output logic [VALUE_W-1:0] value,
    output logic               clip
);

    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [VALUE_W-1:0] ud_reg, ud_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] r_reg, r_next;
    logic [QUO_W-1:0]   q_reg, q_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               clip_reg, clip_next;

    logic [VALUE_W:0]   r_sh;
    logic [QUO_W:0]     q_up;
    logic               round_up;

    always_comb
    begin
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        ud_next    = ud_reg;
        neg_next   = neg_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        value_next = value_reg;
        clip_next  = clip_reg;
        // dividend is a single one at bit 2F, fed in on the first step
        r_sh     = {r_reg, (cnt_reg == 6'(QUO_W - 1))};
        round_up = (r_reg >= (ud_reg - r_reg));
        q_up     = {1'b0, q_reg} + {{QUO_W{1'b0}}, round_up};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(QUO_W - 1);
            ud_next   = mag32(divisor);
            neg_next  = divisor[VALUE_W-1];
            r_next    = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (r_sh >= {1'b0, ud_reg})
            begin
                r_next = VALUE_W'(r_sh - {1'b0, ud_reg});
                q_next = {q_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[VALUE_W-1:0];
                q_next = {q_reg[QUO_W-2:0], 1'b0};
            end
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
            if (!neg_reg)
            begin
                clip_next  = (q_up > (QUO_W+1)'(VAL_MAX));
                value_next = clip_next ? VAL_MAX : q_up[VALUE_W-1:0];
            end
            else
            begin
                clip_next  = (q_up > (QUO_W+1)'(VAL_MIN));
                value_next = clip_next ? VAL_MIN : (~q_up[VALUE_W-1:0] + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ud_reg    <= ud_next;
        neg_reg   <= neg_next;
        r_reg     <= r_next;
        q_reg     <= q_next;
        value_reg <= value_next;
        clip_reg  <= clip_next;
    end

    assign done  = done_reg;
    assign value = value_reg;
    assign clip  = clip_reg;

endmodule

// ----- hdl/lower_triangular_inverse.sv -----
// Inverts the lower triangle of an n x n signed Q16.16 matrix (n from the CFG_SIZE register).
// Each load request writes one entry into the input store, and a following load request is
// taken in the next cycle. The request with load_last set starts the inversion and the block
// stalls loads until the last result has been loaded into the output register. The inversion
// first scans for zero diagonals and upper entries over tolerance, then per row i computes the
// reciprocal (a 33-step restoring divider) and, for each entry below the diagonal, a
// multiply-accumulate through the two store read ports; entries behind a zero diagonal are
// written as zero with STAT_ZERO. Results then leave row-major, each paced by the registered
// read of the inverse store and held while out_stall is high.
module lower_triangular_inverse
    import ltinv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [IDX_W-1:0]   entry_row,
    input  logic [IDX_W-1:0]   entry_col,
    input  logic signed [VALUE_W-1:0] entry_value,
    input  logic               load_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [IDX_W-1:0]   out_row,
    output logic [IDX_W-1:0]   out_col,
    output logic signed [VALUE_W-1:0] out_value,
    output logic               out_last,
    output logic [STAT_W-1:0]  out_status
);

    state_t state_reg, state_next;

    logic [3:0]            size_reg, size_next;
    logic [CFG_W-1:0]      tol_reg, tol_next;
    logic [IDX_W-1:0]      i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0]      sc_r_reg, sc_r_next, sc_c_reg, sc_c_next;
    logic                  sc_issue_reg, sc_issue_next;
    logic                  sc_v_reg, sc_v_next;
    logic [IDX_W-1:0]      sc_vr_reg, sc_vr_next, sc_vc_reg, sc_vc_next;
    logic [MAX_ORDER-1:0]  zdiag_reg, zdiag_next;
    logic                  flag_reg, flag_next;
    logic                  issuing_reg, issuing_next;
    logic                  rd_v_reg, rd_v_next;
    logic                  prod_v_reg, prod_v_next;
    logic [2*VALUE_W-1:0]  prod_reg, prod_next;
    logic                  prod_neg_reg, prod_neg_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0]    inv_reg, inv_next;
    logic [STAT_W-1:0]     dstat_reg, dstat_next;
    logic [PART_W-1:0]     plo_reg, plo_next, phi_reg, phi_next;
    logic [FULL_W-FRAC_W-1:0] m_reg, m_next;
    logic [IDX_W-1:0]      er_reg, er_next, ec_reg, ec_next;
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]      out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic                  out_last_reg, out_last_next;
    logic [STAT_W-1:0]     out_status_reg, out_status_next;

    logic                  in_we, inv_we, div_start, div_done, div_clip, out_load;
    logic [ADDR_W-1:0]     in_raddr, inv_raddr, inv_waddr;
    logic [VALUE_W-1:0]    in_rdata, div_value;
    logic [INV_W-1:0]      inv_rdata, inv_wdata;
    logic [3:0]            n_eff;
    logic [IDX_W-1:0]      n_m1;
    logic [ACC_W-1:0]      acc_mag;
    logic [2*VALUE_W-FRAC_W-1:0] rnd;
    logic [FULL_W-1:0]     p_full;
    logic                  res_pos, fin_clip;
    logic [VALUE_W-1:0]    fin_val;
    logic [STAT_W-1:0]     em_stat;

    ltinv_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr ({entry_row, entry_col}),
        .wdata (entry_value),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    ltinv_ram #(.WIDTH(INV_W), .DEPTH(CELLS)) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_waddr),
        .wdata (inv_wdata),
        .raddr (inv_raddr),
        .rdata (inv_rdata)
    );

    ltinv_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (in_rdata),
        .done    (div_done),
        .value   (div_value),
        .clip    (div_clip)
    );

    assign n_eff    = (size_reg == 4'd0) ? 4'd1 :
                      (size_reg > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : size_reg;
    assign n_m1     = IDX_W'(n_eff - 4'd1);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_we    = in_valid && !in_stall;

    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign rnd      = (2*VALUE_W-FRAC_W)'((prod_reg + (2*VALUE_W)'(1 << (FRAC_W-1))) >> FRAC_W);
    assign p_full   = {phi_reg, {HALF_W{1'b0}}} + FULL_W'(plo_reg)
                      + FULL_W'(1 << (FRAC_W-1));
    // the result is the negated product, so it is positive when signs differ
    assign res_pos  = acc_reg[ACC_W-1] ^ inv_reg[VALUE_W-1];

    always_comb
    begin
        fin_clip = 1'b0;
        fin_val  = '0;
        if (m_reg == '0)
        begin
            fin_val = '0;
        end
        else if (res_pos)
        begin
            fin_clip = (m_reg > (FULL_W-FRAC_W)'(VAL_MAX));
            fin_val  = fin_clip ? VAL_MAX : m_reg[VALUE_W-1:0];
        end
        else
        begin
            fin_clip = (m_reg > (FULL_W-FRAC_W)'(VAL_MIN));
            fin_val  = fin_clip ? VAL_MIN : (~m_reg[VALUE_W-1:0] + 1'b1);
        end
    end

    always_comb
    begin
        em_stat = (ec_reg <= er_reg) ? inv_rdata[INV_W-1:VALUE_W] : STAT_OK;
        if (em_stat == STAT_OK && flag_reg)
        begin
            em_stat = STAT_UPPER;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        tol_next        = tol_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        sc_r_next       = sc_r_reg;
        sc_c_next       = sc_c_reg;
        sc_issue_next   = sc_issue_reg;
        sc_v_next       = 1'b0;
        sc_vr_next      = sc_r_reg;
        sc_vc_next      = sc_c_reg;
        zdiag_next      = zdiag_reg;
        flag_next       = flag_reg;
        issuing_next    = issuing_reg;
        rd_v_next       = 1'b0;
        prod_v_next     = 1'b0;
        prod_next       = mag32(in_rdata) * mag32(inv_rdata[VALUE_W-1:0]);
        prod_neg_next   = in_rdata[VALUE_W-1] ^ inv_rdata[VALUE_W-1];
        acc_next        = acc_reg;
        inv_next        = inv_reg;
        dstat_next      = dstat_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        m_next          = m_reg;
        er_next         = er_reg;
        ec_next         = ec_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_load        = 1'b0;
        div_start       = 1'b0;
        inv_we          = 1'b0;
        inv_waddr       = {i_reg, j_reg};
        inv_wdata       = '0;
        in_raddr        = {i_reg, k_reg};
        inv_raddr       = {k_reg, j_reg};

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE: size_next = cfg_data[3:0];
                CFG_TOL:  tol_next  = cfg_data;
                default:  ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_we && load_last)
                begin
                    state_next    = ST_SCAN;
                    sc_r_next     = '0;
                    sc_c_next     = '0;
                    sc_issue_next = 1'b1;
                    flag_next     = 1'b0;
                end
            end
            ST_SCAN:
            begin
                in_raddr  = {sc_r_reg, sc_c_reg};
                sc_v_next = sc_issue_reg;
                if (sc_issue_reg)
                begin
                    if (sc_c_reg == n_m1)
                    begin
                        sc_c_next = '0;
                        if (sc_r_reg == n_m1)
                        begin
                            sc_issue_next = 1'b0;
                        end
                        else
                        begin
                            sc_r_next = sc_r_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sc_c_next = sc_c_reg + 1'b1;
                    end
                end
                if (sc_v_reg)
                begin
                    if (sc_vr_reg == sc_vc_reg)
                    begin
                        zdiag_next[sc_vr_reg] = (in_rdata == '0);
                    end
                    if (sc_vr_reg < sc_vc_reg && mag32(in_rdata) >= VALUE_W'(tol_reg))
                    begin
                        flag_next = 1'b1;
                    end
                end
                if (!sc_issue_reg && !sc_v_reg)
                begin
                    state_next = ST_DIAG_RD;
                    i_next     = '0;
                end
            end
            ST_DIAG_RD:
            begin
                in_raddr   = {i_reg, i_reg};
                state_next = ST_DIAG_CHK;
            end
            ST_DIAG_CHK:
            begin
                if (in_rdata == '0)
                begin
                    inv_next   = '0;
                    dstat_next = STAT_ZERO;
                    state_next = ST_DIAG_WR;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    inv_next   = div_value;
                    dstat_next = div_clip ? STAT_SAT : STAT_OK;
                    state_next = ST_DIAG_WR;
                end
            end
            ST_DIAG_WR:
            begin
                inv_we    = 1'b1;
                inv_waddr = {i_reg, i_reg};
                inv_wdata = {dstat_reg, inv_reg};
                if (i_reg == '0)
                begin
                    state_next = ST_ROW_END;
                end
                else
                begin
                    j_next     = i_reg - 1'b1;
                    state_next = ST_OFF;
                end
            end
            ST_OFF:
            begin
                if (zero_span(zdiag_reg, i_reg, j_reg))
                begin
                    inv_we    = 1'b1;
                    inv_wdata = {STAT_ZERO, {VALUE_W{1'b0}}};
                    if (j_reg == '0)
                    begin
                        state_next = ST_ROW_END;
                    end
                    else
                    begin
                        j_next = j_reg - 1'b1;
                    end
                end
                else
                begin
                    k_next       = j_reg;
                    issuing_next = 1'b1;
                    acc_next     = '0;
                    state_next   = ST_DOT;
                end
            end
            ST_DOT:
            begin
                // read, multiply, accumulate overlap one term per cycle
                rd_v_next   = issuing_reg;
                prod_v_next = rd_v_reg;
                if (issuing_reg)
                begin
                    if (k_reg == i_reg - 1'b1)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                if (prod_v_reg)
                begin
                    acc_next = prod_neg_reg ? acc_reg - ACC_W'(rnd) : acc_reg + ACC_W'(rnd);
                end
                if (!issuing_reg && !rd_v_reg && !prod_v_reg)
                begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1:
            begin
                plo_next   = PART_W'(acc_mag[HALF_W-1:0]) * PART_W'(mag32(inv_reg));
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                phi_next   = PART_W'(acc_mag[ACC_W-1:HALF_W]) * PART_W'(mag32(inv_reg));
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                m_next     = p_full[FULL_W-1:FRAC_W];
                state_next = ST_FIN_WR;
            end
            ST_FIN_WR:
            begin
                inv_we    = 1'b1;
                inv_wdata = {(fin_clip ? STAT_SAT : STAT_OK), fin_val};
                if (j_reg == '0)
                begin
                    state_next = ST_ROW_END;
                end
                else
                begin
                    j_next     = j_reg - 1'b1;
                    state_next = ST_OFF;
                end
            end
            ST_ROW_END:
            begin
                if (i_reg == n_m1)
                begin
                    er_next    = '0;
                    ec_next    = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_DIAG_RD;
                end
            end
            ST_EMIT_RD:
            begin
                inv_raddr  = {er_reg, ec_reg};
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                inv_raddr = {er_reg, ec_reg};
                if (!out_valid_reg || !out_stall)
                begin
                    out_load        = 1'b1;
                    out_row_next    = er_reg;
                    out_col_next    = ec_reg;
                    out_value_next  = (ec_reg <= er_reg) ? inv_rdata[VALUE_W-1:0] : '0;
                    out_status_next = em_stat;
                    out_last_next   = (er_reg == n_m1) && (ec_reg == n_m1);
                    if (out_last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                        if (ec_reg == n_m1)
                        begin
                            ec_next = '0;
                            er_next = er_reg + 1'b1;
                        end
                        else
                        begin
                            ec_next = ec_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= 4'd8;
            tol_reg       <= 16'd1;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            sc_r_reg      <= '0;
            sc_c_reg      <= '0;
            sc_issue_reg  <= 1'b0;
            sc_v_reg      <= 1'b0;
            zdiag_reg     <= '0;
            flag_reg      <= 1'b0;
            issuing_reg   <= 1'b0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            er_reg        <= '0;
            ec_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            tol_reg       <= tol_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            sc_r_reg      <= sc_r_next;
            sc_c_reg      <= sc_c_next;
            sc_issue_reg  <= sc_issue_next;
            sc_v_reg      <= sc_v_next;
            zdiag_reg     <= zdiag_next;
            flag_reg      <= flag_next;
            issuing_reg   <= issuing_next;
            rd_v_reg      <= rd_v_next;
            prod_v_reg    <= prod_v_next;
            er_reg        <= er_next;
            ec_reg        <= ec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sc_vr_reg      <= sc_vr_next;
        sc_vc_reg      <= sc_vc_next;
        prod_reg       <= prod_next;
        prod_neg_reg   <= prod_neg_next;
        acc_reg        <= acc_next;
        inv_reg        <= inv_next;
        dstat_reg      <= dstat_next;
        plo_reg        <= plo_next;
        phi_reg        <= phi_next;
        m_reg          <= m_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_value  = out_value_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

    a_no_inv_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_SCAN) |-> !inv_we)
        else $error("inverse store written outside inversion");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("reciprocal finished outside its wait state");

    a_k_below_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DOT && issuing_reg) |-> (k_reg < i_reg))
        else $error("dot product index reached the current row");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("final result not followed by idle");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ltinv_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [STAT_W-1:0]  status;
    } inv_entry_t;

    class inverse_scoreboard;
        longint     a_store [CELLS];
        longint     b_store [CELLS];
        int         order_reg = 8;
        int         tol_reg = 1;
        inv_entry_t expected_q [$];
        int         errors = 0;
        int         checked = 0;
        int         inversions = 0;

        function void write_config(logic index, logic [CFG_W-1:0] data);
            if (index == CFG_SIZE)
                order_reg = data[3:0];
            else
                tol_reg = data;
        endfunction

        function logic [63:0] mag64(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint from_mag(bit neg, logic [63:0] m, inout bit clip);
            logic [63:0] lim;
            lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            if (m > lim)
            begin
                m = lim;
                clip = 1;
            end
            return neg ? longint'(-m) : longint'(m);
        endfunction

        function longint clip32(longint v, inout bit clip);
            if (v > 64'sd2147483647)
            begin
                clip = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                clip = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint sat_add(longint a, longint b, inout bit clip);
            longint r;
            r = a + b;
            if (a[63] == b[63] && r[63] != a[63])
            begin
                clip = 1;
                r = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
            end
            return r;
        endfunction

        // rounded fixed point product, clipped to 64 bits
        function longint mul_fix(longint a, longint b, inout bit clip);
            logic [127:0] full;
            logic [63:0]  m;
            full = {64'd0, mag64(a)} * {64'd0, mag64(b)};
            full = full + (128'd1 << (FRAC_W - 1));
            full = full >> FRAC_W;
            m = (full[127:64] != 0) ? '1 : full[63:0];
            return from_mag((a < 0) != (b < 0), m, clip);
        endfunction

        function longint reciprocal_fix(longint d, inout bit clip);
            logic [63:0] ud, q, r;
            ud = mag64(d);
            q = (64'd1 << (2 * FRAC_W)) / ud;
            r = (64'd1 << (2 * FRAC_W)) % ud;
            if (r >= ud - r)
                q = q + 1;
            return clip32(from_mag(d < 0, q, clip), clip);
        endfunction

        function void note_request(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                   logic signed [VALUE_W-1:0] value, logic last);
            int n;
            bit upper_hit;
            bit zero_seen;
            bit clip;
            longint di, inv, acc, v;
            logic [STAT_W-1:0] stat [CELLS];
            inv_entry_t e;
            a_store[{row, col}] = longint'(value);
            if (!last)
                return;
            inversions++;
            n = order_reg < 1 ? 1 : (order_reg > MAX_ORDER ? MAX_ORDER : order_reg);
            upper_hit = 0;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (mag64(a_store[i * MAX_ORDER + j]) >= 64'(tol_reg))
                        upper_hit = 1;
            for (int i = 0; i < n; i++)
            begin
                di = a_store[i * MAX_ORDER + i];
                clip = 0;
                zero_seen = (di == 0);
                inv = zero_seen ? 0 : reciprocal_fix(di, clip);
                b_store[i * MAX_ORDER + i] = inv;
                stat[i * MAX_ORDER + i] = zero_seen ? STAT_ZERO : (clip ? STAT_SAT : STAT_OK);
                for (int j = i - 1; j >= 0; j--)
                begin
                    if (a_store[j * MAX_ORDER + j] == 0)
                        zero_seen = 1;
                    if (zero_seen)
                    begin
                        b_store[i * MAX_ORDER + j] = 0;
                        stat[i * MAX_ORDER + j] = STAT_ZERO;
                    end
                    else
                    begin
                        acc = 0;
                        clip = 0;
                        for (int k = j; k < i; k++)
                            acc = sat_add(acc, mul_fix(a_store[i * MAX_ORDER + k],
                                                       b_store[k * MAX_ORDER + j], clip), clip);
                        v = mul_fix(acc, inv, clip);
                        if (v == 64'sh8000_0000_0000_0000)
                        begin
                            clip = 1;
                            v = 64'sh7fff_ffff_ffff_ffff;
                        end
                        else
                            v = -v;
                        v = clip32(v, clip);
                        b_store[i * MAX_ORDER + j] = v;
                        stat[i * MAX_ORDER + j] = clip ? STAT_SAT : STAT_OK;
                    end
                end
            end
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                begin
                    e.row = IDX_W'(i);
                    e.col = IDX_W'(j);
                    e.value = (j <= i) ? b_store[i * MAX_ORDER + j][31:0] : '0;
                    e.status = (j <= i) ? stat[i * MAX_ORDER + j] : STAT_OK;
                    if (e.status == STAT_OK && upper_hit)
                        e.status = STAT_UPPER;
                    e.last = (i == n - 1 && j == n - 1);
                    expected_q.insert(expected_q.size(), e);
                end
        endfunction

        function void compare_field(string name, longint exp_v, longint got_v);
            if (exp_v != got_v)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(inv_entry_t got);
            inv_entry_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result at row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            compare_field("out_row", e.row, got.row);
            compare_field("out_col", e.col, got.col);
            compare_field("out_value", e.value, got.value);
            compare_field("out_last", e.last, got.last);
            compare_field("out_status", e.status, got.status);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [IDX_W-1:0] entry_row;
    logic [IDX_W-1:0] entry_col;
    logic signed [VALUE_W-1:0] entry_value;
    logic load_last;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic out_last;
    logic [STAT_W-1:0] out_status;

    inverse_scoreboard sb = new();
    bit quiet = 0;
    int loads_sent = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    localparam int WATCHDOG_LIMIT = 6000;

    lower_triangular_inverse DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .entry_row(entry_row), .entry_col(entry_col),
        .entry_value(entry_value), .load_last(load_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_row(out_row), .out_col(out_col), .out_value(out_value),
        .out_last(out_last), .out_status(out_status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (quiet || r < 5)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", sb.expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        inv_entry_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.row = out_row;
            got.col = out_col;
            got.value = out_value;
            got.last = out_last;
            got.status = out_status;
            sb.check_result(got);
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 2) == 0)
        begin
            stall_left <= pick_gap();
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_load(int row, int col, logic [VALUE_W-1:0] value, bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        entry_row <= IDX_W'(row);
        entry_col <= IDX_W'(col);
        entry_value <= value;
        load_last <= last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(IDX_W'(row), IDX_W'(col), value, last);
        loads_sent++;
    endtask

    // waits for the previous inversion to drain before touching a register
    task automatic write_reg(logic index, logic [CFG_W-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_config(index, data);
    endtask

    function logic [VALUE_W-1:0] pick_entry(int r, int c);
        int k;
        k = $urandom_range(0, 19);
        if (r == c)
        begin
            case (k)
                0: return 32'h0;
                1: return 32'h1;
                2: return 32'h8000_0000;
                3: return 32'h7fff_ffff;
                4: return 32'h0001_0000;
                5: return 32'hffff_0000;
                6: return $urandom();
                default: return $urandom_range(16, 32'h0008_0000) * ($urandom_range(0, 1) ? 1 : -1);
            endcase
        end
        if (r > c)
            return (k < 3) ? $urandom() : 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        if (k < 12)
            return 32'h0;
        if (k < 17)
            return $urandom_range(0, 3) * ($urandom_range(0, 1) ? 1 : -1);
        return $urandom();
    endfunction

    task automatic load_matrix(int n);
        int cells [$];
        int t, s, tmp;
        for (int i = 0; i < n * n; i++)
            cells.insert(cells.size(), i);
        for (int i = n * n - 1; i > 0; i--)
        begin
            s = $urandom_range(0, i);
            tmp = cells[i];
            cells[i] = cells[s];
            cells[s] = tmp;
        end
        foreach (cells[i])
        begin
            t = cells[i];
            send_load(t / n, t % n, pick_entry(t / n, t % n), i == n * n - 1);
        end
    endtask

    initial
    begin
        int n;
        int raw;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SIZE;
        cfg_data = '0;
        in_valid = 1'b0;
        entry_row = '0;
        entry_col = '0;
        entry_value = '0;
        load_last = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // order one: unit, zero, tiny and most negative diagonals
        write_reg(CFG_SIZE, 16'd1);
        send_load(0, 0, 32'h0001_0000, 1);
        send_load(0, 0, 32'h0, 1);
        send_load(0, 0, 32'h1, 1);
        send_load(0, 0, 32'h8000_0000, 1);
        // order two with zero tolerance and extreme entries
        write_reg(CFG_TOL, 16'd0);
        write_reg(CFG_SIZE, 16'd2);
        send_load(0, 0, 32'h7fff_ffff, 0);
        send_load(0, 1, 32'h0, 0);
        send_load(1, 0, 32'h8000_0000, 0);
        send_load(1, 1, 32'h0000_0001, 1);
        // widest tolerance, zero on the first diagonal hides the whole column
        write_reg(CFG_TOL, 16'hffff);
        send_load(0, 0, 32'h0, 0);
        send_load(0, 1, 32'h0000_ffff, 0);
        send_load(1, 0, 32'h0002_0000, 0);
        send_load(1, 1, 32'hfffe_0000, 1);

        // random matrices, first at the largest order via an oversized setting
        for (int m = 0; loads_sent < 168; m++)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if (m == 0)
                raw = 15;
            else if (m == 1)
                raw = 0;
            else if (loads_sent > 100)
                raw = $urandom_range(1, 3);
            else if ($urandom_range(0, 2) == 0)
                raw = $urandom_range(1, 5);
            else
                raw = -1;
            if (raw >= 0)
                write_reg(CFG_SIZE, {12'($urandom_range(0, 12'hfff)), 4'(raw)});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_TOL, ($urandom_range(0, 2) == 0) ? CFG_W'($urandom())
                                                               : CFG_W'($urandom_range(0, 4)));
            n = sb.order_reg < 1 ? 1 : (sb.order_reg > MAX_ORDER ? MAX_ORDER : sb.order_reg);
            // stray loads that do not start an inversion
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3))
                    send_load($urandom_range(0, 7), $urandom_range(0, 7), $urandom(), 0);
            load_matrix(n);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        quiet = 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("sent %0d load requests over %0d inversions", loads_sent, sb.inversions);
        $display("checked %0d inverse entries with random gaps and stalls", sb.checked);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ltinv_pkg.sv
hdl/ltinv_ram.sv
hdl/ltinv_recip.sv
hdl/lower_triangular_inverse.sv
sim/tb.sv
